// ===== src/rvalu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvalu_pkg: shared types and constants for the RV32I ALU execute block
// Decoded-operation record, opcode and funct codes, register file and queue
// sizing.
// ----------------------------------------------------------------------------
package rvalu_pkg;

    // Architectural register count (16..32); indexes at or above it are illegal.
    localparam int REG_COUNT = 32;
    localparam int RF_IDX_W  = $clog2(REG_COUNT);
    localparam logic [5:0] REG_LIMIT = 6'(REG_COUNT);

    // Decoupling queue between decode and execute
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Major opcodes
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;

    // funct7 patterns
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 ALU codes
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // Operand A source
    localparam logic [1:0] ASEL_RS1  = 2'd0;
    localparam logic [1:0] ASEL_PC   = 2'd1;
    localparam logic [1:0] ASEL_ZERO = 2'd2;

    typedef struct packed {
        logic [31:0] pc;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  funct3;
        logic        alt;      // SUB / arithmetic right shift
        logic [1:0]  a_sel;
        logic        b_imm;    // operand B from immediate, else rs2
        logic [31:0] imm;
        logic        bad;
    } rvalu_op_t;

    typedef struct packed {
        logic      valid;
        rvalu_op_t op;
    } rvalu_slot_t;

endpackage

`default_nettype wire

// ===== src/rvalu_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvalu_front: instruction accept and decode
// Holds the program counter, classifies each instruction word and pushes the
// decoded operation into the queue.
// ----------------------------------------------------------------------------
module rvalu_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [31:0]           cfg_wdata,
    input  wire logic                  instr_valid,
    output logic                       instr_stall,
    input  wire logic [31:0]           instruction_word,
    input  wire logic                  queue_full,
    output rvalu_pkg::rvalu_slot_t     push
);
    import rvalu_pkg::*;

    logic [31:0] pc_reg;
    logic [31:0] pc_next;
    logic        accept;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [6:0]  f7;
    logic        rs1_oor;
    logic        rs2_oor;
    logic        rd_oor;
    rvalu_op_t   dec;

    assign instr_stall = queue_full;
    assign accept      = instr_valid && !queue_full;

    assign opc = instruction_word[6:0];
    assign rd  = instruction_word[11:7];
    assign f3  = instruction_word[14:12];
    assign rs1 = instruction_word[19:15];
    assign rs2 = instruction_word[24:20];
    assign f7  = instruction_word[31:25];

    assign rs1_oor = {1'b0, rs1} >= REG_LIMIT;
    assign rs2_oor = {1'b0, rs2} >= REG_LIMIT;
    assign rd_oor  = {1'b0, rd}  >= REG_LIMIT;

    always_comb
    begin
        dec        = '0;
        dec.pc     = pc_reg;
        dec.rd     = rd;
        dec.rs1    = rs1;
        dec.rs2    = rs2;
        dec.funct3 = F3_ADD;
        dec.a_sel  = ASEL_ZERO;
        dec.b_imm  = 1'b1;
        dec.imm    = {instruction_word[31:12], 12'h000};
        unique case (opc)
            OPC_OP_IMM:
            begin
                dec.funct3 = f3;
                dec.a_sel  = ASEL_RS1;
                dec.imm    = {{20{instruction_word[31]}}, instruction_word[31:20]};
                dec.alt    = (f3 == F3_SR) && (f7 == F7_ALT);
                // shift immediates must carry a clean funct7
                if (f3 == F3_SLL && f7 != F7_BASE)
                    dec.bad = 1'b1;
                if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)
                    dec.bad = 1'b1;
                if (rs1_oor)
                    dec.bad = 1'b1;
            end
            OPC_OP:
            begin
                dec.funct3 = f3;
                dec.a_sel  = ASEL_RS1;
                dec.b_imm  = 1'b0;
                dec.alt    = (f7 == F7_ALT) && (f3 == F3_ADD || f3 == F3_SR);
                if (f7 != F7_BASE && !dec.alt)
                    dec.bad = 1'b1;
                if (rs1_oor || rs2_oor)
                    dec.bad = 1'b1;
            end
            OPC_LUI:
            begin
                dec.a_sel = ASEL_ZERO;
            end
            OPC_AUIPC:
            begin
                dec.a_sel = ASEL_PC;
            end
            default:
            begin
                dec.bad = 1'b1;
            end
        endcase
        if (rd_oor)
            dec.bad = 1'b1;
    end

    assign push.valid = accept;
    assign push.op    = dec;

    always_comb
    begin
        pc_next = pc_reg;
        if (cfg_we)
            pc_next = cfg_wdata;
        else if (accept)
            pc_next = pc_reg + 32'd4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

// ===== src/rvalu_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvalu_queue: decoupling queue
// Small FIFO of decoded operations between decode and execute.
// ----------------------------------------------------------------------------
module rvalu_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rvalu_pkg::rvalu_slot_t push,
    output logic                       full,
    output rvalu_pkg::rvalu_slot_t     head,
    input  wire logic                  pop
);
    import rvalu_pkg::*;

    rvalu_op_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.op    = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push.op;
    end

endmodule

`default_nettype wire

// ===== src/rvalu_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rvalu_back: register file read, ALU, writeback and result register
// Registered register file read with one-entry write forwarding, then the
// ALU feeding the output register.
// ----------------------------------------------------------------------------
module rvalu_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rvalu_pkg::rvalu_slot_t head,
    output logic                       pop,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic [31:0]                instruction_pc,
    output logic [4:0]                 dest_index,
    output logic [31:0]                write_value,
    output logic                       write_enable,
    output logic                       illegal_flag
);
    import rvalu_pkg::*;

    // register file (x0 never written), valid bits stand in for reset-to-zero
    logic [31:0]          rf_mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic [31:0]          rd1_reg;
    logic [31:0]          rd2_reg;

    // last write, forwarded to the execute stage
    logic                 fwd_valid_reg;
    logic [4:0]           fwd_idx_reg;
    logic [31:0]          fwd_data_reg;

    logic                 exe_valid_reg;
    rvalu_op_t            exe_op_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_pc_reg;
    logic [4:0]           out_rd_reg;
    logic [31:0]          out_value_reg;
    logic                 out_we_reg;
    logic                 out_bad_reg;

    logic                 out_adv;
    logic                 exe_fire;
    logic                 rf_we;
    logic [RF_IDX_W-1:0]  rs1_idx;
    logic [RF_IDX_W-1:0]  rs2_idx;
    logic [RF_IDX_W-1:0]  rd_idx;
    logic [31:0]          src1;
    logic [31:0]          src2;
    logic [31:0]          op_a;
    logic [31:0]          op_b;
    logic [31:0]          alu_out;
    logic [31:0]          value;
    logic                 we;

    assign out_adv  = !out_valid_reg || !result_stall;
    assign exe_fire = exe_valid_reg && out_adv;
    assign pop      = head.valid && (!exe_valid_reg || out_adv);

    assign rs1_idx = head.op.rs1[RF_IDX_W-1:0];
    assign rs2_idx = head.op.rs2[RF_IDX_W-1:0];
    assign rd_idx  = exe_op_reg.rd[RF_IDX_W-1:0];

    // source operands: x0 reads zero, newest write wins
    always_comb
    begin
        if (exe_op_reg.rs1 == 5'd0)
            src1 = '0;
        else if (fwd_valid_reg && fwd_idx_reg == exe_op_reg.rs1)
            src1 = fwd_data_reg;
        else
            src1 = rd1_reg;
        if (exe_op_reg.rs2 == 5'd0)
            src2 = '0;
        else if (fwd_valid_reg && fwd_idx_reg == exe_op_reg.rs2)
            src2 = fwd_data_reg;
        else
            src2 = rd2_reg;
    end

    always_comb
    begin
        unique case (exe_op_reg.a_sel)
            ASEL_RS1: op_a = src1;
            ASEL_PC:  op_a = exe_op_reg.pc;
            default:  op_a = '0;
        endcase
        op_b = exe_op_reg.b_imm ? exe_op_reg.imm : src2;
    end

    always_comb
    begin
        unique case (exe_op_reg.funct3)
            F3_ADD:  alu_out = exe_op_reg.alt ? op_a - op_b : op_a + op_b;
            F3_SLL:  alu_out = op_a << op_b[4:0];
            F3_SLT:  alu_out = {31'd0, $signed(op_a) < $signed(op_b)};
            F3_SLTU: alu_out = {31'd0, op_a < op_b};
            F3_XOR:  alu_out = op_a ^ op_b;
            F3_SR:   alu_out = exe_op_reg.alt ? 32'($signed(op_a) >>> op_b[4:0])
                                              : op_a >> op_b[4:0];
            F3_OR:   alu_out = op_a | op_b;
            F3_AND:  alu_out = op_a & op_b;
            default: alu_out = '0;
        endcase
    end

    assign value = exe_op_reg.bad ? 32'd0 : alu_out;
    assign we    = !exe_op_reg.bad && exe_op_reg.rd != 5'd0;
    assign rf_we = exe_fire && we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exe_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            if (pop)
                exe_valid_reg <= 1'b1;
            else if (out_adv)
                exe_valid_reg <= 1'b0;
            if (out_adv)
                out_valid_reg <= exe_valid_reg;
            if (rf_we)
            begin
                fwd_valid_reg        <= 1'b1;
                rf_valid_reg[rd_idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            exe_op_reg <= head.op;
            rd1_reg    <= rf_valid_reg[rs1_idx] ? rf_mem_reg[rs1_idx] : 32'd0;
            rd2_reg    <= rf_valid_reg[rs2_idx] ? rf_mem_reg[rs2_idx] : 32'd0;
        end
        if (rf_we)
        begin
            rf_mem_reg[rd_idx] <= value;
            fwd_idx_reg        <= exe_op_reg.rd;
            fwd_data_reg       <= value;
        end
        if (exe_fire)
        begin
            out_pc_reg    <= exe_op_reg.pc;
            out_rd_reg    <= exe_op_reg.rd;
            out_value_reg <= value;
            out_we_reg    <= we;
            out_bad_reg   <= exe_op_reg.bad;
        end
    end

    assign result_valid   = out_valid_reg;
    assign instruction_pc = out_pc_reg;
    assign dest_index     = out_rd_reg;
    assign write_value    = out_value_reg;
    assign write_enable   = out_we_reg;
    assign illegal_flag   = out_bad_reg;

endmodule

`default_nettype wire

// ===== src/rv32i_integer_alu_execute.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rv32i_integer_alu_execute: RV32I integer ALU execute block
// Executes OP-IMM, OP, LUI and AUIPC against a 32 x 32 register file and
// reports one result transaction per instruction.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+---------------------------------
//  instr    | instr_valid / instr_stall  | instruction_word
//  result   | result_valid / result_stall| instruction_pc, dest_index,
//           |                            | write_value, write_enable,
//           |                            | illegal_flag
//  cfg      | cfg_we (no wait)           | cfg_wdata = start_address
//
//  One instruction per cycle sustained while result_stall is low. The result
//  register loads in order after the queue write at the accepting edge and
//  the register file read, taking the ALU result.
//  The register file read port is registered; the most recent write is
//  forwarded into the ALU so dependent instructions issue back to back.
//  Reset clears the pc to zero and marks every register as zero via
//  per-entry valid bits. A stalled result holds the execute stage; the
//  two-entry queue keeps accepting until full, then instr_stall rises.
//
module rv32i_integer_alu_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        instr_valid,
    output logic             instr_stall,
    input  wire logic [31:0] instruction_word,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      instruction_pc,
    output logic [4:0]       dest_index,
    output logic [31:0]      write_value,
    output logic             write_enable,
    output logic             illegal_flag
);
    import rvalu_pkg::*;

    rvalu_slot_t push;
    rvalu_slot_t head;
    logic        queue_full;
    logic        pop;

    // decode: owns the pc, classifies the instruction
    rvalu_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .instr_valid      (instr_valid),
        .instr_stall      (instr_stall),
        .instruction_word (instruction_word),
        .queue_full       (queue_full),
        .push             (push)
    );

    // decouples decode from execute stalls
    rvalu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    // register file, ALU, writeback, result register
    rvalu_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .instruction_pc (instruction_pc),
        .dest_index     (dest_index),
        .write_value    (write_value),
        .write_enable   (write_enable),
        .illegal_flag   (illegal_flag)
    );

endmodule

`default_nettype wire
